[design/fsdp_pkg.sv]
// Shared definitions for the printf-style decimal formatter.
// Character codes, controller state type, the link structs between the
// controller and the serial BCD converter, and the digit-count helper.
package fsdp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ARG_WIDTH       = 32;
	localparam int CHAR_WIDTH      = 8;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_DIGIT
	} fsdp_state_t;

	typedef struct packed {
		logic load;
		logic shift_digit;
	} bcd_ctrl_t;

	typedef struct packed {
		logic busy;
	} bcd_stat_t;

	// Decimal digits needed for an unsigned magnitude of the given width:
	// floor(width * log10(2)) + 1.
	function automatic int digit_count(input int width);
		return (width * 30103) / 100000 + 1;
	endfunction

endpackage

[design/fsdp_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3) with a digit-wide
// output shifter. Depends on fsdp_pkg for the control structs and digit count.
module fsdp_bcd #(
	parameter int VALUE_WIDTH = fsdp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsdp_pkg::bcd_ctrl_t     ctrl,
	input  logic [VALUE_WIDTH-1:0]  mag,
	output fsdp_pkg::bcd_stat_t     stat,
	output logic [3:0]              digit
);
	import fsdp_pkg::*;

	localparam int ND = digit_count(VALUE_WIDTH);
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [4*ND-1:0]        bcd_q;
	logic [4*ND-1:0]        bcd_adj;
	logic [CW-1:0]          cnt_q;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= CW'(VALUE_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[4*ND-2:0], bin_q[VALUE_WIDTH-1]};
		end else if (ctrl.shift_digit) begin
			bcd_q <= {bcd_q[4*ND-5:0], 4'b0000};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign digit     = bcd_q[4*ND-1 -: 4];

endmodule

[design/format_string_decimal_printer.sv]
// Top level of the printf "%d" formatter: format byte parser, controller
// and output register. Depends on fsdp_pkg and instantiates fsdp_bcd.
//
//  Channel  | Direction | tdata (low bit up)                 | tlast
//  ---------+-----------+------------------------------------+----------------------
//  s_axis   | in        | fmt_char[7:0], arg_value[39:8]     | -
//  m_axis   | out       | out_char[7:0]                      | last char of the item
//
// An ordinary byte is echoed with tlast set. A '%', a NUL or a swallowed
// byte gives no transaction. A byte that completes "%d" is accepted and
// runs through the serial BCD loop; then a minus sign is emitted for a
// negative value, leading zeros are skipped one at a time, and each
// remaining digit is emitted as one character.
// Reset clears the pending '%' flag and the controller; there is no clearing
// pass. A stalled m_axis holds the current character and stops the emitter;
// s_axis_tready stays low until the previous item is fully handed over.
module format_string_decimal_printer #(
	parameter int VALUE_WIDTH = fsdp_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // fmt_char[7:0], arg_value[39:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_char[7:0]
	output logic        m_axis_tlast    // last
);
	import fsdp_pkg::*;

	localparam int ND = digit_count(VALUE_WIDTH);
	localparam int DW = $clog2(ND + 1);

	fsdp_state_t st_q, st_d;

	logic                   pend_q;
	logic                   neg_q;
	logic [DW-1:0]          dig_q;
	logic                   m_valid_q;
	logic [7:0]             m_data_q;
	logic                   m_last_q;

	logic [7:0]             fmt;
	logic [ARG_WIDTH-1:0]   arg;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   slot_free;
	logic                   accept;
	logic                   start_dec;
	logic                   echo;
	logic                   skip_zero;
	logic                   emit;
	logic [7:0]             emit_char;
	logic                   emit_last;
	logic [3:0]             digit;
	bcd_ctrl_t              ctrl;
	bcd_stat_t              stat;

	assign fmt = s_axis_tdata[7:0];
	assign arg = s_axis_tdata[39:8];

	// The argument is read as a VALUE_WIDTH-bit two's complement value;
	// bits above the 32 that arrive are zero.
	generate
		if (VALUE_WIDTH > ARG_WIDTH) begin : g_wide
			assign raw = {{(VALUE_WIDTH-ARG_WIDTH){1'b0}}, arg};
		end else begin : g_narrow
			assign raw = arg[VALUE_WIDTH-1:0];
		end
	endgenerate

	// The most negative value negates to itself, which read as unsigned is
	// its true magnitude.
	assign mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

	assign slot_free     = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE) && slot_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start_dec     = accept && (fmt != CH_NUL) && pend_q && (fmt == CH_D);
	assign echo          = accept && (fmt != CH_NUL) && !pend_q && (fmt != CH_PERCENT);

	// A leading zero is dropped unless it is the only digit left.
	assign skip_zero = (digit == 4'd0) && (dig_q > DW'(1));

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (start_dec) st_d = ST_CONV;
			end
			ST_CONV: begin
				if (!stat.busy) st_d = neg_q ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				if (slot_free) st_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_zero) st_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (slot_free && dig_q == DW'(1)) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.load        = start_dec;
		ctrl.shift_digit = 1'b0;
		emit             = 1'b0;
		emit_char        = CH_NUL;
		emit_last        = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (echo) begin
					emit      = 1'b1;
					emit_char = fmt;
					emit_last = 1'b1;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_char = CH_MINUS;
				end
			end
			ST_SKIP: begin
				ctrl.shift_digit = skip_zero;
			end
			ST_DIGIT: begin
				if (slot_free) begin
					emit             = 1'b1;
					emit_char        = CH_ZERO + {4'b0000, digit};
					emit_last        = (dig_q == DW'(1));
					ctrl.shift_digit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				if (fmt == CH_NUL || pend_q) begin
					pend_q <= 1'b0;
				end else if (fmt == CH_PERCENT) begin
					pend_q <= 1'b1;
				end
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_dec) begin
			neg_q <= raw[VALUE_WIDTH-1];
			dig_q <= DW'(ND);
		end else if (ctrl.shift_digit) begin
			dig_q <= dig_q - DW'(1);
		end
		if (emit) begin
			m_data_q <= emit_char;
			m_last_q <= emit_last;
		end
	end

	fsdp_bcd #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.mag   (mag),
		.stat  (stat),
		.digit (digit)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	// No new item is taken while a conversion or its emission is under way.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input accepted outside idle");

	// A completed "%d" starts the serial converter at once.
	a_conv_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_dec |=> (st_q == ST_CONV) && stat.busy)
		else $error("conversion did not start");

	// The digit counter never runs out while digits are still emitted.
	a_dig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SKIP || st_q == ST_DIGIT) |-> (dig_q != '0))
		else $error("digit counter underflow");

	// The final digit carries tlast and returns the controller to idle.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIGIT && emit && dig_q == DW'(1)) |=>
		(st_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
		else $error("last digit not flagged");

endmodule
